// File: rtl/lcg_pkg.sv
// Shared constants for the line colour gradient block.
`default_nettype none
package lcg_pkg;
  localparam int COORD_BITS_DEF     = 16;
  localparam int DIST_FRAC_BITS_DEF = 8;
  localparam int CHAN_BITS          = 8;
  localparam int NUM_CHAN           = 3;
  localparam int COLOR_BITS         = CHAN_BITS * NUM_CHAN;
  localparam int SIDE_BITS          = 2 * COLOR_BITS;
endpackage
`default_nettype wire

// File: rtl/lcg_if.sv
// Request and result channel interfaces for the line colour gradient block.
`default_nettype none
interface lcg_in_if #(parameter int CW = 16);
  logic                valid;
  logic                ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic [23:0]          start_color;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic [23:0]          end_color;
  logic signed [CW-1:0] pixel_x;
  logic signed [CW-1:0] pixel_y;
  modport source (output valid, start_x, start_y, start_color, end_x, end_y, end_color,
                  pixel_x, pixel_y, input ready);
  modport sink (input valid, start_x, start_y, start_color, end_x, end_y, end_color,
                pixel_x, pixel_y, output ready);
endinterface

interface lcg_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_color;
  modport source (output valid, pixel_color, input ready);
  modport sink (input valid, pixel_color, output ready);
endinterface
`default_nettype wire

// File: rtl/lcg_dist.sv
// Squared distance pipeline: difference, square, sum for two point pairs.
`default_nettype none
module lcg_dist
  import lcg_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF,
  parameter int SW = SIDE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic signed [CW-1:0]  ax [2],
  input  wire logic signed [CW-1:0]  ay [2],
  input  wire logic signed [CW-1:0]  bx [2],
  input  wire logic signed [CW-1:0]  by [2],
  input  wire logic [SW-1:0]         side_in,
  output logic                       out_valid,
  output logic [2*CW+1:0]            dsq [2],
  output logic [SW-1:0]              side_out
);
  logic [2:0]       vld;
  logic [CW:0]      ux [2];
  logic [CW:0]      uy [2];
  logic [2*CW+1:0]  sx [2];
  logic [2*CW+1:0]  sy [2];
  logic [SW-1:0]    side [3];
  logic signed [CW:0] dx [2];
  logic signed [CW:0] dy [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dx[l] = {ax[l][CW-1], ax[l]} - {bx[l][CW-1], bx[l]};
      dy[l] = {ay[l][CW-1], ay[l]} - {by[l][CW-1], by[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        ux[l]  <= dx[l][CW] ? (~dx[l] + 1'b1) : dx[l];
        uy[l]  <= dy[l][CW] ? (~dy[l] + 1'b1) : dy[l];
        sx[l]  <= ux[l] * ux[l];
        sy[l]  <= uy[l] * uy[l];
        dsq[l] <= sx[l] + sy[l];
      end
      side[0] <= side_in;
      side[1] <= side[0];
      side[2] <= side[1];
    end
  end

  assign out_valid = vld[2];
  assign side_out  = side[2];
endmodule
`default_nettype wire

// File: rtl/lcg_sqrt.sv
// Pipelined fixed-point square root, one result bit per stage, two lanes.
`default_nettype none
module lcg_sqrt
  import lcg_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF,
  parameter int FB = DIST_FRAC_BITS_DEF,
  parameter int SW = SIDE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [2*CW+1:0]     v_in [2],
  input  wire logic [SW-1:0]       side_in,
  output logic                     out_valid,
  output logic [CW+FB+1:0]         root_out [2],
  output logic [SW-1:0]            side_out
);
  localparam int RW  = CW + 2 + FB;
  localparam int P   = RW;
  localparam int VW  = 2 * (CW + 2);
  localparam int RMW = RW + 3;

  logic           vld    [P+1];
  logic [RMW-1:0] rem_q  [P+1][2];
  logic [RW-1:0]  root_q [P+1][2];
  logic [VW-1:0]  v_q    [P+1][2];
  logic [SW-1:0]  side_q [P+1];

  always_comb begin
    vld[0]    = in_valid;
    side_q[0] = side_in;
    for (int l = 0; l < 2; l++) begin
      rem_q[0][l]  = '0;
      root_q[0][l] = '0;
      v_q[0][l]    = {2'b00, v_in[l]};
    end
  end

  for (genvar i = 0; i < P; i++) begin : g_stage
    logic [RMW-1:0] rem_sh [2];
    logic [RMW-1:0] trial  [2];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rem_sh[l] = {rem_q[i][l][RMW-3:0], v_q[i][l][VW-1 -: 2]};
        trial[l]  = {1'b0, root_q[i][l], 2'b01};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          if (rem_sh[l] >= trial[l]) begin
            rem_q[i+1][l]  <= rem_sh[l] - trial[l];
            root_q[i+1][l] <= {root_q[i][l][RW-2:0], 1'b1};
          end else begin
            rem_q[i+1][l]  <= rem_sh[l];
            root_q[i+1][l] <= {root_q[i][l][RW-2:0], 1'b0};
          end
          v_q[i+1][l] <= {v_q[i][l][VW-3:0], 2'b00};
        end
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign out_valid   = vld[P];
  assign root_out[0] = root_q[P][0];
  assign root_out[1] = root_q[P][1];
  assign side_out    = side_q[P];
endmodule
`default_nettype wire

// File: rtl/lcg_blend.sv
// Colour blend pipeline: traveled distance, product, 8-step divider, assemble.
`default_nettype none
module lcg_blend
  import lcg_pkg::*;
#(
  parameter int RW = COORD_BITS_DEF + 2 + DIST_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [RW-1:0]         len,
  input  wire logic [RW-1:0]         rem,
  input  wire logic [COLOR_BITS-1:0] sc,
  input  wire logic [COLOR_BITS-1:0] ec,
  output logic                       out_valid,
  output logic [COLOR_BITS-1:0]      color
);
  localparam int PW = RW + CHAN_BITS;
  localparam int ND = CHAN_BITS;

  // stage A: traveled distance and channel differences
  logic                 a_vld;
  logic [RW-1:0]        a_trav, a_div;
  logic [CHAN_BITS-1:0] a_s [NUM_CHAN];
  logic [CHAN_BITS-1:0] a_n [NUM_CHAN];
  logic                 a_dir [NUM_CHAN];
  // stage B: products
  logic                 b_vld;
  logic [RW-1:0]        b_div;
  logic [PW-1:0]        b_prod [NUM_CHAN];
  logic [CHAN_BITS-1:0] b_s [NUM_CHAN];
  logic                 b_dir [NUM_CHAN];
  // divider stages
  logic                 d_vld  [ND+1];
  logic [RW-1:0]        d_div  [ND+1];
  logic [RW-1:0]        d_p    [ND+1][NUM_CHAN];
  logic [ND-1:0]        d_lo   [ND+1][NUM_CHAN];
  logic [ND-1:0]        d_q    [ND+1][NUM_CHAN];
  logic [CHAN_BITS-1:0] d_s    [ND+1][NUM_CHAN];
  logic                 d_dir  [ND+1][NUM_CHAN];
  logic                 o_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
      o_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
      b_vld <= a_vld;
      o_vld <= d_vld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_trav <= (rem >= len) ? '0 : len - rem;
      // zero length: traveled is zero, so any non-zero divisor yields the start colour
      a_div  <= (len == '0) ? RW'(1) : len;
      for (int c = 0; c < NUM_CHAN; c++) begin
        a_s[c]   <= sc[c*CHAN_BITS +: CHAN_BITS];
        a_dir[c] <= ec[c*CHAN_BITS +: CHAN_BITS] < sc[c*CHAN_BITS +: CHAN_BITS];
        a_n[c]   <= (ec[c*CHAN_BITS +: CHAN_BITS] < sc[c*CHAN_BITS +: CHAN_BITS])
                    ? sc[c*CHAN_BITS +: CHAN_BITS] - ec[c*CHAN_BITS +: CHAN_BITS]
                    : ec[c*CHAN_BITS +: CHAN_BITS] - sc[c*CHAN_BITS +: CHAN_BITS];
      end
      b_div <= a_div;
      for (int c = 0; c < NUM_CHAN; c++) begin
        b_prod[c] <= a_n[c] * a_trav;
        b_s[c]    <= a_s[c];
        b_dir[c]  <= a_dir[c];
      end
    end
  end

  always_comb begin
    d_vld[0] = b_vld;
    d_div[0] = b_div;
    for (int c = 0; c < NUM_CHAN; c++) begin
      d_p[0][c]   = b_prod[c][PW-1 -: RW];
      d_lo[0][c]  = b_prod[c][ND-1:0];
      d_q[0][c]   = '0;
      d_s[0][c]   = b_s[c];
      d_dir[0][c] = b_dir[c];
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [RW:0] p_sh [NUM_CHAN];

    always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        p_sh[c] = {d_p[k][c], d_lo[k][c][ND-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[k+1] <= 1'b0;
      end else if (en) begin
        d_vld[k+1] <= d_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_div[k+1] <= d_div[k];
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (p_sh[c] >= {1'b0, d_div[k]}) begin
            d_p[k+1][c] <= RW'(p_sh[c] - {1'b0, d_div[k]});
            d_q[k+1][c] <= {d_q[k][c][ND-2:0], 1'b1};
          end else begin
            d_p[k+1][c] <= p_sh[c][RW-1:0];
            d_q[k+1][c] <= {d_q[k][c][ND-2:0], 1'b0};
          end
          d_lo[k+1][c]  <= {d_lo[k][c][ND-2:0], 1'b0};
          d_s[k+1][c]   <= d_s[k][c];
          d_dir[k+1][c] <= d_dir[k][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        color[c*CHAN_BITS +: CHAN_BITS] <= d_dir[ND][c] ? d_s[ND][c] - d_q[ND][c]
                                                         : d_s[ND][c] + d_q[ND][c];
      end
    end
  end

  assign out_valid = o_vld;
endmodule
`default_nettype wire

// File: rtl/line_color_gradient_top.sv
// Top level of the line colour gradient block.
// One pixel colour per request, one request a cycle while the pipeline does not
// hold. The stages: squared distance (difference, square, sum), one square root stage per
// result bit (COORD_BITS + 2 + DIST_FRAC_BITS), then traveled distance,
// product, eight divider steps and the output register. The pipeline advances as
// one: it holds whenever a result waits at the output and the sink is not ready.
`default_nettype none
module line_color_gradient_top
  import lcg_pkg::*;
#(
  parameter int COORD_BITS     = COORD_BITS_DEF,
  parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  lcg_in_if.sink   in_chan,
  lcg_out_if.source out_chan
);
  localparam int RW = COORD_BITS + 2 + DIST_FRAC_BITS;

  logic                   en;
  logic signed [COORD_BITS-1:0] ax [2];
  logic signed [COORD_BITS-1:0] ay [2];
  logic signed [COORD_BITS-1:0] bx [2];
  logic signed [COORD_BITS-1:0] by [2];
  logic                   dist_vld, sqrt_vld, out_vld;
  logic [2*COORD_BITS+1:0] dsq [2];
  logic [SIDE_BITS-1:0]   dist_side, sqrt_side;
  logic [RW-1:0]          roots [2];
  logic [COLOR_BITS-1:0]  color;

  // advance everything unless a result is held at the output
  assign en            = !out_vld || out_chan.ready;
  assign in_chan.ready = en;

  // lane 0: segment length, lane 1: pixel to end point
  assign ax[0] = in_chan.start_x;
  assign ay[0] = in_chan.start_y;
  assign bx[0] = in_chan.end_x;
  assign by[0] = in_chan.end_y;
  assign ax[1] = in_chan.end_x;
  assign ay[1] = in_chan.end_y;
  assign bx[1] = in_chan.pixel_x;
  assign by[1] = in_chan.pixel_y;

  lcg_dist #(.CW(COORD_BITS), .SW(SIDE_BITS)) u_dist (
    .clk, .rst, .en,
    .in_valid (in_chan.valid),
    .ax, .ay, .bx, .by,
    .side_in  ({in_chan.start_color, in_chan.end_color}),
    .out_valid(dist_vld),
    .dsq,
    .side_out (dist_side)
  );

  lcg_sqrt #(.CW(COORD_BITS), .FB(DIST_FRAC_BITS), .SW(SIDE_BITS)) u_sqrt (
    .clk, .rst, .en,
    .in_valid (dist_vld),
    .v_in     (dsq),
    .side_in  (dist_side),
    .out_valid(sqrt_vld),
    .root_out (roots),
    .side_out (sqrt_side)
  );

  lcg_blend #(.RW(RW)) u_blend (
    .clk, .rst, .en,
    .in_valid (sqrt_vld),
    .len      (roots[0]),
    .rem      (roots[1]),
    .sc       (sqrt_side[SIDE_BITS-1 -: COLOR_BITS]),
    .ec       (sqrt_side[COLOR_BITS-1:0]),
    .out_valid(out_vld),
    .color
  );

  assign out_chan.valid       = out_vld;
  assign out_chan.pixel_color = color;

  // a held result must keep its colour until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_chan.ready |=> out_vld && $stable(color))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_vld)
    else $error("result valid straight after reset");
endmodule
`default_nettype wire

// File: tb/line_color_gradient_top_tb.sv
// Self-checking testbench for the line colour gradient block.
`default_nettype none
module line_color_gradient_top_tb
  import lcg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB        = COORD_BITS_DEF;
  localparam int FB        = DIST_FRAC_BITS_DEF;
  localparam int LATENCY   = CB + FB + 16;
  localparam int MAX_CYCLES = 400000;
  localparam int N_RANDOM  = 1600;

  typedef struct {
    logic signed [CB-1:0] sx, sy, ex, ey, px, py;
    logic [COLOR_BITS-1:0] sc, ec;
  } seg_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   mismatches = 0;
  bit   idle_en = 1'b1;

  lcg_in_if #(.CW(CB)) in_chan ();
  lcg_out_if out_chan ();

  line_color_gradient_top dut (
    .clk(clk), .rst(rst), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  logic [COLOR_BITS-1:0] colour_expected_q[$];

  initial begin
    forever #2 clk = ~clk;
  end

  // Floor of sqrt(v) scaled by 2^FB, two bits per step.
  function automatic longint unsigned fixed_root(longint unsigned v);
    longint unsigned root, rmd, trial, bits;
    int pairs;
    root = 0;
    rmd = 0;
    pairs = CB + 2;
    for (int i = 0; i < pairs + FB; i++) begin
      bits = (i < pairs) ? ((v >> (2 * (pairs - 1 - i))) & 3) : 0;
      rmd = (rmd << 2) | bits;
      trial = (root << 2) | 1;
      if (rmd >= trial) begin
        rmd -= trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic longint unsigned span_sq(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return longint'(dx * dx + dy * dy);
  endfunction

  function automatic logic [CHAN_BITS-1:0] blend_channel(longint unsigned s, longint unsigned e,
                                                         longint unsigned trav,
                                                         longint unsigned len);
    if (e >= s) return CHAN_BITS'(s + ((e - s) * trav) / len);
    return CHAN_BITS'(s - ((s - e) * trav) / len);
  endfunction

  function automatic logic [COLOR_BITS-1:0] gradient_colour(seg_req_t r);
    longint unsigned len, remain, trav;
    logic [COLOR_BITS-1:0] c;
    len = fixed_root(span_sq(r.sx, r.sy, r.ex, r.ey));
    if (len == 0) return r.sc;
    remain = fixed_root(span_sq(r.ex, r.ey, r.px, r.py));
    trav = (remain >= len) ? 0 : len - remain;
    for (int k = 0; k < NUM_CHAN; k++)
      c[k*CHAN_BITS +: CHAN_BITS] = blend_channel(r.sc[k*CHAN_BITS +: CHAN_BITS],
                                                  r.ec[k*CHAN_BITS +: CHAN_BITS], trav, len);
    return c;
  endfunction

  // Stall the result side at random; idle_en clears for a stall-free stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= !(idle_en && $urandom_range(99) < 35);
    end
  end

  // Check each accepted result against the oldest expected colour.
  always @(posedge clk) begin
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (colour_expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %06h", $time,
                 out_chan.pixel_color);
        mismatches++;
      end else begin
        if (out_chan.pixel_color !== colour_expected_q[0]) begin
          $display("%0t: pixel_color mismatch, expected %06h, actual %06h", $time,
                   colour_expected_q[0], out_chan.pixel_color);
          mismatches++;
        end
        void'(colour_expected_q.pop_front());
      end
    end
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive one request, hold it until accepted, then queue its colour.
  // Valid drops only while idling, so each edge sees one assignment to it.
  task automatic send_request(seg_req_t r);
    while (idle_en && $urandom_range(99) < 35) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.start_x <= r.sx;
    in_chan.start_y <= r.sy;
    in_chan.start_color <= r.sc;
    in_chan.end_x <= r.ex;
    in_chan.end_y <= r.ey;
    in_chan.end_color <= r.ec;
    in_chan.pixel_x <= r.px;
    in_chan.pixel_y <= r.py;
    do @(posedge clk); while (!in_chan.ready);
    colour_expected_q.push_back(gradient_colour(r));
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (colour_expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic seg_req_t make_req(int sx, int sy, int ex, int ey, int px, int py,
                                        logic [23:0] sc, logic [23:0] ec);
    seg_req_t r;
    r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey; r.px = px; r.py = py;
    r.sc = sc; r.ec = ec;
    return r;
  endfunction

  // Extremes, zero-length segment, far pixel, off-line pixel, endpoints.
  task automatic test_directed();
    send_request(make_req(0, 0, 0, 0, 5, 5, 24'h123456, 24'hFEDCBA));
    send_request(make_req(-32768, -32768, -32768, -32768, 0, 0, 24'hFFFFFF, 24'h000000));
    send_request(make_req(-32768, -32768, 32767, 32767, 32767, 32767, 24'h000000, 24'hFFFFFF));
    send_request(make_req(-32768, -32768, 32767, 32767, -32768, -32768, 24'hFFFFFF, 24'h000000));
    send_request(make_req(-32768, 32767, 32767, -32768, 0, 0, 24'h00FF00, 24'hFF00FF));
    send_request(make_req(0, 0, 100, 0, 50, 0, 24'h000000, 24'hFFFFFF));
    send_request(make_req(0, 0, 100, 0, 50, 0, 24'hFFFFFF, 24'h000000));
    send_request(make_req(0, 0, 10, 0, -500, 0, 24'h102030, 24'hA0B0C0));
    send_request(make_req(0, 0, 10, 0, 3, 7, 24'h102030, 24'hA0B0C0));
    send_request(make_req(0, 0, 1, 1, 1, 1, 24'h0000FF, 24'hFF0000));
    send_request(make_req(0, 0, 3, 4, 0, 0, 24'hAA55AA, 24'h55AA55));
    send_request(make_req(0, 0, 3, 4, 1, 1, 24'hAA55AA, 24'h55AA55));
    send_request(make_req(32767, 32767, -32768, -32768, 32767, -32768, 24'h808080, 24'h7F7F7F));
    send_request(make_req(5, -5, 5, 5, 5, 0, 24'hFFFFFF, 24'hFFFFFF));
    send_request(make_req(-1, -1, 1, 1, 0, 0, 24'h010203, 24'hFEFDFC));
  endtask

  function automatic int rand_coord();
    return int'($signed(16'($urandom())));
  endfunction

  // Mostly pixels near a random segment, some wholly random points.
  task automatic test_random(int count);
    seg_req_t r;
    int dx, dy, span, step;
    for (int i = 0; i < count; i++) begin
      r.sc = 24'($urandom());
      r.ec = 24'($urandom());
      if ($urandom_range(4) == 0) begin
        r.sx = rand_coord(); r.sy = rand_coord();
        r.ex = rand_coord(); r.ey = rand_coord();
        r.px = rand_coord(); r.py = rand_coord();
      end else begin
        span = ($urandom_range(1) == 0) ? 64 : 16000;
        r.sx = $urandom_range(2 * span) - span; r.sy = $urandom_range(2 * span) - span;
        r.ex = $urandom_range(2 * span) - span; r.ey = $urandom_range(2 * span) - span;
        dx = int'(r.ex) - int'(r.sx);
        dy = int'(r.ey) - int'(r.sy);
        step = $urandom_range(256);
        r.px = int'(r.sx) + (dx * step) / 256 + int'($urandom_range(4)) - 2;
        r.py = int'(r.sy) + (dy * step) / 256 + int'($urandom_range(4)) - 2;
        if ($urandom_range(15) == 0) r.ex = r.sx;
        if ($urandom_range(15) == 0) r.ey = r.sy;
      end
      send_request(r);
    end
  endtask

  // Run at full rate on both sides, then pause the sender until all results return.
  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random(200);
    idle_en = 1'b1;
    drain_results();
  endtask

  initial begin
    in_chan.valid <= 1'b0;
    in_chan.start_x <= '0;
    in_chan.start_y <= '0;
    in_chan.start_color <= '0;
    in_chan.end_x <= '0;
    in_chan.end_y <= '0;
    in_chan.end_color <= '0;
    in_chan.pixel_x <= '0;
    in_chan.pixel_y <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(N_RANDOM / 2);
    test_back_to_back();
    test_random(N_RANDOM / 2 - 200);
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && colour_expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
